// File: design/qce_pkg.sv
// ----------------------------------------------------------------------------
// qce_pkg
// Shared types, constants and saturating helpers of the quartic evaluator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package qce_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int MAX_ORDER     = 4;

   localparam logic signed [63:0] ACC_MIN = {1'b1, {63{1'b0}}};
   localparam logic signed [63:0] ACC_MAX = {1'b0, {63{1'b1}}};

   // falling factorials k!/(k-j)! of the derivative of order j
   localparam logic [4:0] DFAC [0:4][0:4] = '{
      '{5'd1, 5'd0, 5'd0,  5'd0,  5'd0},
      '{5'd1, 5'd1, 5'd0,  5'd0,  5'd0},
      '{5'd1, 5'd2, 5'd2,  5'd0,  5'd0},
      '{5'd1, 5'd3, 5'd6,  5'd6,  5'd0},
      '{5'd1, 5'd4, 5'd12, 5'd24, 5'd24}
   };

   typedef enum logic [2:0] {
      CSR_START_POS = 3'd0,
      CSR_START_VEL = 3'd1,
      CSR_START_ACC = 3'd2,
      CSR_END_POS   = 3'd3,
      CSR_END_VEL   = 3'd4,
      CSR_HORIZON   = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [2:0]         deriv_order;
      logic signed [31:0] position;
   } req_type;

   typedef struct packed {
      logic signed [31:0] value;
      logic               overflow;
   } rsp_type;

   typedef struct packed {
      logic               zero;
      logic [2:0]         order;
      logic signed [31:0] position;
   } item_type;

   typedef struct packed {
      logic signed [31:0] start_pos;
      logic signed [31:0] start_vel;
      logic signed [31:0] start_acc;
      logic signed [31:0] end_pos;
      logic signed [31:0] end_vel;
      logic [30:0]        horizon;
   } cfg_type;

   typedef struct packed {
      logic signed [63:0] c3;
      logic signed [63:0] c4;
      logic               sat3;
      logic               sat4;
   } coef_type;

   typedef struct packed {
      logic signed [63:0] value;
      logic               sat;
   } sat_word_type;

   function automatic sat_word_type sadd(input logic signed [63:0] a,
                                         input logic signed [63:0] b);
      logic signed [64:0] sum;
      sat_word_type       r;
      sum = 65'(a) + 65'(b);
      if (sum[64] != sum[63]) begin
         r.sat   = 1'b1;
         r.value = sum[64] ? ACC_MIN : ACC_MAX;
      end else begin
         r.sat   = 1'b0;
         r.value = sum[63:0];
      end
      return r;
   endfunction

   function automatic sat_word_type smulk(input logic signed [63:0] a,
                                          input logic [4:0] k);
      logic signed [69:0] prod;
      sat_word_type       r;
      prod = 70'(a) * $signed({65'b0, k});
      if (prod[69:63] != {7{prod[63]}}) begin
         r.sat   = 1'b1;
         r.value = prod[69] ? ACC_MIN : ACC_MAX;
      end else begin
         r.sat   = 1'b0;
         r.value = prod[63:0];
      end
      return r;
   endfunction

   function automatic logic [63:0] mag64(input logic signed [63:0] a);
      return a[63] ? (~a + 64'd1) : a;
   endfunction

   function automatic sat_word_type from_mag(input logic neg, input logic [64:0] mag);
      logic [64:0]  lim;
      sat_word_type r;
      lim = neg ? {2'b01, {63{1'b0}}} : {2'b00, {63{1'b1}}};
      if (mag > lim) begin
         r.sat   = 1'b1;
         r.value = neg ? ACC_MIN : ACC_MAX;
      end else begin
         r.sat   = 1'b0;
         r.value = neg ? (~mag[63:0] + 64'd1) : mag[63:0];
      end
      return r;
   endfunction

   function automatic logic [4:0] dfac(input logic [2:0] row, input logic [2:0] k);
      logic [4:0] f;
      f = 5'd0;
      if (row <= 3'(MAX_ORDER) && k <= row) begin
         f = DFAC[row][k];
      end
      return f;
   endfunction

endpackage

`default_nettype wire

// File: design/quartic_curve_evaluator.sv
// ----------------------------------------------------------------------------
// quartic_curve_evaluator
// Throughput: one query word per cycle while busy is low; the Horner pipeline never stalls.
// A register write refits c3/c4 in the shared bit-serial divider; busy stays high
// until the fit is done.
// Reset (synchronous) restores register defaults and runs that same fit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module quartic_curve_evaluator #(
   parameter int FRAC_BITS = qce_pkg::FRAC_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   // query channel
   input  wire logic             start,
   output logic                  busy,
   input  wire qce_pkg::req_type req_data,
   // result channel, one strobe per word, no back-pressure
   output logic                  rsp_valid,
   output qce_pkg::rsp_type      rsp_data,
   // register write port
   input  wire logic             csr_we,
   input  wire logic [2:0]       csr_index,
   input  wire logic [31:0]      csr_wdata
);

   // boundary-condition registers
   qce_pkg::cfg_type  cfg_ff, cfg_in;
   qce_pkg::coef_type coef;
   qce_pkg::item_type head;
   logic              fit_busy, q_full, head_valid, accept;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            qce_pkg::CSR_START_POS: cfg_in.start_pos = csr_wdata;
            qce_pkg::CSR_START_VEL: cfg_in.start_vel = csr_wdata;
            qce_pkg::CSR_START_ACC: cfg_in.start_acc = csr_wdata;
            qce_pkg::CSR_END_POS:   cfg_in.end_pos   = csr_wdata;
            qce_pkg::CSR_END_VEL:   cfg_in.end_vel   = csr_wdata;
            qce_pkg::CSR_HORIZON:   cfg_in.horizon   = csr_wdata[30:0];
            default:                cfg_in           = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         // all zero, horizon 1.0
         cfg_ff <= '{start_pos: '0, start_vel: '0, start_acc: '0,
                     end_pos: '0, end_vel: '0, horizon: 31'd1 << FRAC_BITS};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // refuse words while the fit runs or the queue is full
   assign busy   = fit_busy || q_full;
   assign accept = start && !busy;

   qce_fit #(.FRAC_BITS(FRAC_BITS)) u_fit (
      .clock   (clock),
      .reset   (reset),
      .restart (csr_we),
      .cfg     (cfg_ff),
      .coef    (coef),
      .busy    (fit_busy)
   );

   // front end: classifies orders above four as zero words
   qce_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .req        (req_data),
      .pop        (1'b1),
      .head_valid (head_valid),
      .head       (head),
      .full       (q_full)
   );

   // back end takes the queue head every cycle
   qce_back #(.FRAC_BITS(FRAC_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (head_valid),
      .in_item   (head),
      .cfg       (cfg_ff),
      .coef      (coef),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_data)
   );

`ifndef SYNTH
   localparam int LATENCY = 16;

   a_cfg_refit: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> busy)
      else $error("register write did not start a refit");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_valid)
      else $error("result word missing at fixed latency");

   a_zero_order: assert property (@(posedge clock) disable iff (reset)
      (accept && req_data.deriv_order > 3'(qce_pkg::MAX_ORDER)) |->
      ##LATENCY (rsp_data.value == '0 && !rsp_data.overflow))
      else $error("order above four gave a non-zero word");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe straight after reset");
`endif

endmodule

`default_nettype wire

// File: design/qce_div.sv
// ----------------------------------------------------------------------------
// qce_div
// Bit-serial divider: v * 2^FRAC_BITS / h, rounded, saturated to 64 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qce_div #(
   parameter int FRAC_BITS = qce_pkg::FRAC_BITS_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               go,
   input  wire logic signed [63:0] dividend,
   input  wire logic [30:0]        divisor,
   output logic                    done,
   output qce_pkg::sat_word_type   result
);

   localparam int STEPS = 64 + FRAC_BITS;
   localparam int CNT_W = $clog2(STEPS);

   logic             run_ff, run_in, fin_ff, fin_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [63:0]      num_ff, num_in, quo_ff, quo_in;
   logic [31:0]      rem_ff, rem_in;
   logic             big_ff, big_in, neg_ff, neg_in;

   logic [31:0] rem_sh;
   logic        ge;
   logic        rnd;
   logic [64:0] quo_r;

   always_comb begin
      rem_sh = {rem_ff[30:0], num_ff[63]};
      ge     = rem_sh >= {1'b0, divisor};
      run_in = run_ff;
      fin_in = 1'b0;
      cnt_in = cnt_ff;
      num_in = num_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      big_in = big_ff;
      neg_in = neg_ff;
      if (go) begin
         run_in = 1'b1;
         cnt_in = '0;
         num_in = qce_pkg::mag64(dividend);
         neg_in = dividend[63];
         quo_in = '0;
         rem_in = '0;
         big_in = 1'b0;
      end else if (run_ff) begin
         num_in = {num_ff[62:0], 1'b0};
         rem_in = ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
         big_in = big_ff | quo_ff[63];
         quo_in = {quo_ff[62:0], ge};
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(STEPS - 1)) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         fin_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         run_ff <= run_in;
         fin_ff <= fin_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      big_ff <= big_in;
      neg_ff <= neg_in;
   end

   // round half up on the remainder unless the quotient is already past range
   always_comb begin
      rnd   = (quo_ff <= {1'b1, 63'b0}) && ({1'b0, rem_ff, 1'b0} >= {3'b0, divisor});
      quo_r = {1'b0, quo_ff} + {64'b0, rnd};
      if (big_ff) begin
         result.sat   = 1'b1;
         result.value = neg_ff ? qce_pkg::ACC_MIN : qce_pkg::ACC_MAX;
      end else begin
         result = qce_pkg::from_mag(neg_ff, quo_r);
      end
   end

   assign done = fin_ff;

endmodule

`default_nettype wire

// File: design/qce_fit.sv
// ----------------------------------------------------------------------------
// qce_fit
// Coefficient fit sequencer: forms c3 and c4 by repeated division by T.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qce_fit #(
   parameter int FRAC_BITS = qce_pkg::FRAC_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             restart,
   input  wire qce_pkg::cfg_type cfg,
   output qce_pkg::coef_type     coef,
   output logic                  busy
);

   typedef enum logic [2:0] {
      FIT_IDLE = 3'b001,
      FIT_RUN  = 3'b010,
      FIT_WAIT = 3'b100
   } fit_state_type;

   localparam logic [3:0] STEP_C3_FIRST = 4'd0;
   localparam logic [3:0] STEP_C3_VEL   = 4'd1;
   localparam logic [3:0] STEP_C3_ACC   = 4'd3;
   localparam logic [3:0] STEP_C3_LAST  = 4'd4;
   localparam logic [3:0] STEP_C4_FIRST = 4'd5;
   localparam logic [3:0] STEP_C4_VEL   = 4'd6;
   localparam logic [3:0] STEP_C4_ACC   = 4'd8;
   localparam logic [3:0] STEP_C4_LAST  = 4'd10;

   fit_state_type      state_ff, state_in;
   logic               pend_ff, pend_in;
   logic [3:0]         step_ff, step_in;
   logic signed [63:0] s_ff, s_in;
   logic               flag_ff, flag_in;
   qce_pkg::coef_type  coef_ff, coef_in;

   logic signed [63:0] x0, v0, a0, x1, v1, d;
   logic signed [63:0] first_c3, first_c4, addend, dividend;
   logic [30:0]        divisor;
   logic               go, done;
   qce_pkg::sat_word_type quo, sum;

   always_comb begin
      x0 = 64'(cfg.start_pos);
      v0 = 64'(cfg.start_vel);
      a0 = 64'(cfg.start_acc);
      x1 = 64'(cfg.end_pos);
      v1 = 64'(cfg.end_vel);
      d  = x1 - x0;
      first_c3 = d <<< (FRAC_BITS + 2);
      first_c4 = (-(d * 64'sd3)) <<< FRAC_BITS;
      divisor  = (cfg.horizon == '0) ? 31'd1 : cfg.horizon;
      unique case (step_ff)
         STEP_C3_VEL: addend = (-(v0 * 64'sd3 + v1)) <<< FRAC_BITS;
         STEP_C3_ACC: addend = (-a0) <<< FRAC_BITS;
         STEP_C4_VEL: addend = (v0 * 64'sd2 + v1) <<< FRAC_BITS;
         default:     addend = a0 <<< (FRAC_BITS - 1);
      endcase
      priority if (step_ff == STEP_C3_FIRST) dividend = first_c3;
      else if (step_ff == STEP_C4_FIRST)     dividend = first_c4;
      else                                   dividend = s_ff;
      sum = qce_pkg::sadd(s_ff, addend);
   end

   qce_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .go       (go),
      .dividend (dividend),
      .divisor  (divisor),
      .done     (done),
      .result   (quo)
   );

   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      step_in  = step_ff;
      s_in     = s_ff;
      flag_in  = flag_ff;
      coef_in  = coef_ff;
      go       = 1'b0;
      unique case (state_ff)
         FIT_IDLE: begin
            if (pend_ff) begin
               pend_in  = 1'b0;
               step_in  = STEP_C3_FIRST;
               state_in = FIT_RUN;
            end
         end
         FIT_RUN: begin
            if (step_ff == STEP_C3_VEL || step_ff == STEP_C3_ACC ||
                step_ff == STEP_C4_VEL || step_ff == STEP_C4_ACC) begin
               s_in    = sum.value;
               flag_in = flag_ff | sum.sat;
               step_in = step_ff + 4'd1;
            end else begin
               go       = 1'b1;
               state_in = FIT_WAIT;
               if (step_ff == STEP_C3_FIRST || step_ff == STEP_C4_FIRST) begin
                  flag_in = 1'b0;
               end
            end
         end
         FIT_WAIT: begin
            if (done) begin
               s_in    = quo.value;
               flag_in = flag_ff | quo.sat;
               if (step_ff == STEP_C3_LAST) begin
                  coef_in.c3   = quo.value;
                  coef_in.sat3 = flag_ff | quo.sat;
               end
               if (step_ff == STEP_C4_LAST) begin
                  coef_in.c4   = quo.value;
                  coef_in.sat4 = flag_ff | quo.sat;
                  state_in     = FIT_IDLE;
               end else begin
                  step_in  = step_ff + 4'd1;
                  state_in = FIT_RUN;
               end
            end
         end
         default: state_in = FIT_IDLE;
      endcase
      // a register write mid-fit starts the fit over
      if (restart) begin
         pend_in  = 1'b1;
         state_in = FIT_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FIT_IDLE;
         pend_ff  <= 1'b1;
         step_ff  <= STEP_C3_FIRST;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      s_ff    <= s_in;
      flag_ff <= flag_in;
      coef_ff <= coef_in;
   end

   assign coef = coef_ff;
   assign busy = (state_ff != FIT_IDLE) || pend_ff;

endmodule

`default_nettype wire

// File: design/qce_front.sv
// ----------------------------------------------------------------------------
// qce_front
// Query intake: registers and classifies each word, queues it for the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qce_front (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             accept,
   input  wire qce_pkg::req_type req,
   input  wire logic             pop,
   output logic                  head_valid,
   output qce_pkg::item_type     head,
   output logic                  full
);

   qce_pkg::item_type item_ff, item_in;
   logic              item_vld_ff;
   qce_pkg::item_type mem_ff [2];
   logic              wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0]        cnt_ff, cnt_in;
   logic              push, take;

   always_comb begin
      item_in.zero     = req.deriv_order > 3'(qce_pkg::MAX_ORDER);
      item_in.order    = req.deriv_order;
      item_in.position = req.position;
      push    = item_vld_ff;
      take    = pop && (cnt_ff != 2'd0);
      wptr_in = wptr_ff ^ push;
      rptr_in = rptr_ff ^ take;
      cnt_in  = cnt_ff + {1'b0, push} - {1'b0, take};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_vld_ff <= 1'b0;
         wptr_ff     <= 1'b0;
         rptr_ff     <= 1'b0;
         cnt_ff      <= 2'd0;
      end else begin
         item_vld_ff <= accept;
         wptr_ff     <= wptr_in;
         rptr_ff     <= rptr_in;
         cnt_ff      <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (push) begin
         mem_ff[wptr_ff] <= item_ff;
      end
   end

   assign head_valid = cnt_ff != 2'd0;
   assign head       = mem_ff[rptr_ff];
   assign full       = cnt_ff == 2'd2;

endmodule

`default_nettype wire

// File: design/qce_back.sv
// ----------------------------------------------------------------------------
// qce_back
// Horner pipeline: one step of three stages per coefficient c3 down to c0, then rounding.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module qce_back #(
   parameter int FRAC_BITS = qce_pkg::FRAC_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire qce_pkg::item_type in_item,
   input  wire qce_pkg::cfg_type  cfg,
   input  wire qce_pkg::coef_type coef,
   output logic                   rsp_valid,
   output qce_pkg::rsp_type       rsp
);

   localparam int STEPS = qce_pkg::MAX_ORDER;
   localparam int NSTG  = 1 + 3 * STEPS;

   typedef struct packed {
      logic               zero;
      logic [2:0]         order;
      logic signed [31:0] position;
      logic signed [63:0] acc;
      logic               sat;
      logic               neg;
      logic [63:0]        ph;
      logic [63:0]        pl;
      logic signed [63:0] term;
   } lane_type;

   logic [NSTG:0]      vld_ff;
   logic signed [63:0] coef_w [0:4];
   lane_type           init_ff, init_in;
   lane_type           lane_w [0:STEPS];
   qce_pkg::rsp_type   rsp_ff, rsp_in;

   qce_pkg::sat_word_type init_prod;

   always_comb begin
      coef_w[0] = 64'(cfg.start_pos) <<< FRAC_BITS;
      coef_w[1] = 64'(cfg.start_vel) <<< FRAC_BITS;
      coef_w[2] = 64'(cfg.start_acc) <<< (FRAC_BITS - 1);
      coef_w[3] = coef.c3;
      coef_w[4] = coef.c4;
   end

   always_comb begin
      init_prod        = qce_pkg::smulk(coef.c4, qce_pkg::dfac(3'(STEPS), in_item.order));
      init_in          = '0;
      init_in.zero     = in_item.zero;
      init_in.order    = in_item.order;
      init_in.position = in_item.position;
      init_in.acc      = init_prod.value;
      init_in.sat      = init_prod.sat | coef.sat4 |
                         ((in_item.order <= 3'(STEPS - 1)) & coef.sat3);
   end

   always_ff @(posedge clock) begin
      init_ff <= init_in;
   end

   assign lane_w[0] = init_ff;

   for (genvar j = 0; j < STEPS; j++) begin : g_step
      localparam int I = STEPS - 1 - j;

      lane_type a_ff, a_in, b_ff, b_in, c_ff, c_in;
      logic [63:0]           m;
      logic [31:0]           n;
      logic [96:0]           full;
      qce_pkg::sat_word_type term, prod, sum;

      // multiply stage: magnitudes and two 32x32 partial products
      always_comb begin
         a_in = lane_w[j];
         m    = qce_pkg::mag64(lane_w[j].acc);
         n    = lane_w[j].position[31] ? (~lane_w[j].position + 32'd1)
                                       : lane_w[j].position;
         term = qce_pkg::smulk(coef_w[I], qce_pkg::dfac(3'(I), lane_w[j].order));
         if (lane_w[j].order <= 3'(I)) begin
            a_in.neg  = lane_w[j].acc[63] ^ lane_w[j].position[31];
            a_in.ph   = 64'(m[63:32]) * 64'(n);
            a_in.pl   = 64'(m[31:0]) * 64'(n);
            a_in.term = term.value;
            a_in.sat  = lane_w[j].sat | term.sat;
         end
      end

      // combine, round to the accumulator scale and saturate
      always_comb begin
         b_in = a_ff;
         full = {1'b0, a_ff.ph, 32'b0} + {33'b0, a_ff.pl} +
                (97'd1 << (FRAC_BITS - 1));
         if (full[96:64+FRAC_BITS] != '0) begin
            prod.sat   = 1'b1;
            prod.value = a_ff.neg ? qce_pkg::ACC_MIN : qce_pkg::ACC_MAX;
         end else begin
            prod = qce_pkg::from_mag(a_ff.neg, {1'b0, full[63+FRAC_BITS:FRAC_BITS]});
         end
         if (a_ff.order <= 3'(I)) begin
            b_in.acc = prod.value;
            b_in.sat = a_ff.sat | prod.sat;
         end
      end

      // add the scaled coefficient
      always_comb begin
         c_in = b_ff;
         sum  = qce_pkg::sadd(b_ff.acc, b_ff.term);
         if (b_ff.order <= 3'(I)) begin
            c_in.acc = sum.value;
            c_in.sat = b_ff.sat | sum.sat;
         end
      end

      always_ff @(posedge clock) begin
         a_ff <= a_in;
         b_ff <= b_in;
         c_ff <= c_in;
      end

      assign lane_w[j+1] = c_ff;
   end

   logic        fin_neg;
   logic [64:0] fin_rnd;
   logic [64:0] fin_mag;
   logic [64:0] fin_lim;
   logic [31:0] fin_m;
   logic        fin_sat;

   always_comb begin
      fin_neg = lane_w[STEPS].acc[63];
      fin_rnd = {1'b0, qce_pkg::mag64(lane_w[STEPS].acc)} + (65'd1 << (FRAC_BITS - 1));
      fin_mag = fin_rnd >> FRAC_BITS;
      fin_lim = fin_neg ? 65'h0_8000_0000 : 65'h0_7FFF_FFFF;
      fin_sat = fin_mag > fin_lim;
      fin_m   = fin_sat ? fin_lim[31:0] : fin_mag[31:0];
      if (lane_w[STEPS].zero) begin
         rsp_in.value    = '0;
         rsp_in.overflow = 1'b0;
      end else begin
         rsp_in.value    = fin_neg ? (~fin_m + 32'd1) : fin_m;
         rsp_in.overflow = lane_w[STEPS].sat | fin_sat;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[NSTG-1:0], in_valid};
      end
   end

   assign rsp_valid = vld_ff[NSTG];
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire
